// File: sv/positional_list_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared assertion helpers, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine package
// Command and status codes, cell operations and the cell command bundle.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 5;

  // Command codes carried by the opcode field.
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_REAR  = 3'd4,
    OP_DEL_POS   = 3'd5,
    OP_DISPLAY   = 3'd6,
    OP_SEARCH    = 3'd7
  } opcode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // Operation that every cell of the chain carries out.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  // Command broadcast to all cells.
  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] key;
  } cell_cmd_t;

endpackage

// File: sv/ple_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine cell
// Holds one list entry; shifts toward or from its neighbors on insert,
// delete and rotate, and flags a match against the search key.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] left_val,
  input  logic [DATA_W-1:0] right_val,
  output logic [DATA_W-1:0] val,
  output logic              match
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  // Entry update: past the insert point a cell takes its left neighbor, at it
  // the new value; from the delete point on, or on rotate, its right neighbor.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_HOLD: begin
        val <= val;
      end
      CELL_INS: begin
        if (MY_IDX > cmd.idx) begin
          val <= left_val;
        end else if (MY_IDX == cmd.idx) begin
          val <= cmd.value;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          val <= right_val;
        end
      end
      CELL_ROT: begin
        val <= right_val;
      end
      default: begin
        val <= val;
      end
    endcase
    match <= (val == cmd.key);
  end

endmodule

// File: sv/positional_list_engine_unit.sv
`timescale 1ns / 1ps
// An insert or delete is held in the command register and its result is loaded in S_EXEC;
// a search passes S_EXEC and S_SRCH. Display emits one item per cycle while the output
// does not stall, and then rotates the chain back home; the input stays stalled until S_IDLE.
// The single command register takes no new item until the current command is through.
// Reset clears the item count, the control state and the result valid; entries are not cleared.
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of unsigned items held in a chain of cells, with deque and
// positional insert/delete, key search and an in-order display run.
// ----------------------------------------------------------------------------
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [DATA_W-1:0] item_value,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] search_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [DATA_W-1:0] data_value,
  output logic [LEN_W-1:0]  list_length,
  output logic              last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] LAST_ROT = CW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_DISP
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     k;
  opcode_t           op_r;
  logic [DATA_W-1:0] item_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] key_r;
  status_t           out_status;
  logic [DATA_W-1:0] out_data;
  logic [CW-1:0]     out_len;
  logic              out_last;

  cell_cmd_t         cell_cmd;
  logic [DATA_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]  match_vec;

  logic              out_free;
  logic              out_load;
  logic              full;
  logic              empty;
  logic [WW-1:0]     pos_w;
  logic [WW-1:0]     cnt_w;
  logic [WW-1:0]     ins_idx;
  logic [WW-1:0]     del_idx;
  logic              del_bad;
  logic              found;
  logic              rot_go;
  logic [DATA_W-1:0] del_val;
  logic [CW+LEN_W-1:0] len_ext;

  // Cell chain; the last cell's right neighbor wraps to the first for rotation.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_val[0];
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_wrap
      assign right_v = cell_val[0];
    end else begin : g_next
      assign right_v = cell_val[i+1];
    end
    ple_cell #(.INDEX(i)) u_cell (
      .clk       (clk),
      .cmd       (cell_cmd),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i]),
      .match     (match_vec[i])
    );
  end

  // Position decode for the held command.
  always_comb begin
    out_free = !out_valid || !out_stall;
    full     = (count == FULL_CNT);
    empty    = (count == '0);
    pos_w    = WW'(pos_r);
    cnt_w    = WW'(count);
    unique case (op_r)
      OP_INS_FRONT: ins_idx = '0;
      OP_INS_REAR:  ins_idx = cnt_w;
      default: begin
        if (pos_w <= WW'(1)) begin
          ins_idx = '0;
        end else if ((pos_w - WW'(1)) < cnt_w) begin
          ins_idx = pos_w - WW'(1);
        end else begin
          ins_idx = cnt_w;
        end
      end
    endcase
    unique case (op_r)
      OP_DEL_FRONT: del_idx = '0;
      OP_DEL_REAR:  del_idx = cnt_w - WW'(1);
      default: begin
        del_idx = (pos_w <= WW'(1)) ? '0 : (pos_w - WW'(1));
      end
    endcase
    del_bad = (op_r == OP_DEL_POS) && (pos_w > WW'(1)) && (pos_w > cnt_w);
    del_val = cell_val[del_idx[IW-1:0]];
    rot_go  = (k >= count) || out_free;
    // A result item is registered in this cycle.
    out_load = ((state == S_EXEC) && out_free &&
                (empty || ((op_r != OP_DISPLAY) && (op_r != OP_SEARCH)))) ||
               ((state == S_SRCH) && out_free) ||
               ((state == S_DISP) && rot_go && (k < count));
  end

  // Search result: any matching cell inside the held length.
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_vec[i] && (CW'(i) < count)) begin
        found = 1'b1;
      end
    end
  end

  // Command broadcast to the cell chain.
  always_comb begin
    cell_cmd.op    = CELL_HOLD;
    cell_cmd.idx   = '0;
    cell_cmd.value = item_r;
    cell_cmd.key   = key_r;
    if (state == S_EXEC && out_free) begin
      if ((op_r == OP_INS_FRONT || op_r == OP_INS_REAR || op_r == OP_INS_POS) && !full) begin
        cell_cmd.op  = CELL_INS;
        cell_cmd.idx = ins_idx[POS_W-1:0];
      end else if ((op_r == OP_DEL_FRONT || op_r == OP_DEL_REAR || op_r == OP_DEL_POS) &&
                   !empty && !del_bad) begin
        cell_cmd.op  = CELL_DEL;
        cell_cmd.idx = del_idx[POS_W-1:0];
      end
    end else if (state == S_DISP && rot_go) begin
      cell_cmd.op = CELL_ROT;
    end
  end

  // Control state, item count and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= opcode_t'(opcode);
            item_r <= item_value;
            pos_r  <= position;
            key_r  <= search_key;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            out_last <= 1'b1;
            unique case (op_r)
              OP_INS_FRONT, OP_INS_REAR, OP_INS_POS: begin
                out_data <= '0;
                state    <= S_IDLE;
                if (full) begin
                  out_status <= ST_FULL;
                  out_len    <= count;
                end else begin
                  out_status <= ST_OK;
                  count      <= count + CW'(1);
                  out_len    <= count + CW'(1);
                end
              end
              OP_DEL_FRONT, OP_DEL_REAR, OP_DEL_POS: begin
                state <= S_IDLE;
                if (empty) begin
                  out_status <= ST_EMPTY;
                  out_data   <= '0;
                  out_len    <= count;
                end else if (del_bad) begin
                  out_status <= ST_BAD_POS;
                  out_data   <= '0;
                  out_len    <= count;
                end else begin
                  out_status <= ST_OK;
                  out_data   <= del_val;
                  count      <= count - CW'(1);
                  out_len    <= count - CW'(1);
                end
              end
              OP_DISPLAY: begin
                out_data <= '0;
                out_len  <= count;
                if (empty) begin
                  out_status <= ST_EMPTY;
                  state      <= S_IDLE;
                end else begin
                  k     <= '0;
                  state <= S_DISP;
                end
              end
              OP_SEARCH: begin
                out_data <= '0;
                out_len  <= count;
                if (empty) begin
                  out_status <= ST_EMPTY;
                  state      <= S_IDLE;
                end else begin
                  state <= S_SRCH;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SRCH: begin
          if (out_free) begin
            out_status <= found ? ST_FOUND : ST_NOT_FOUND;
            out_data   <= '0;
            out_len    <= count;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_DISP: begin
          // Emit the head while items remain, then rotate the rest back home.
          if (rot_go) begin
            k <= k + CW'(1);
            if (k < count) begin
              out_status <= ST_OK;
              out_data   <= cell_val[0];
              out_len    <= count;
              out_last   <= ((k + CW'(1)) == count);
            end
            if (k == LAST_ROT) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Port drive.
  assign in_stall    = (state != S_IDLE);
  assign status      = out_status;
  assign data_value  = out_data;
  assign len_ext     = {{LEN_W{1'b0}}, out_len};
  assign list_length = len_ext[LEN_W-1:0];
  assign last        = out_last;

endmodule

// File: sv/ple_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine checker
// Watches the result port of the list engine over time.
// ----------------------------------------------------------------------------
`include "positional_list_engine_unit_macros.svh"

module ple_checker
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [2:0]        status,
  input logic [DATA_W-1:0] data_value,
  input logic [LEN_W-1:0]  list_length,
  input logic              last
);

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(DEPTH);

  // A stalled result item stays on the port unchanged.
  `PLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(data_value) && $stable(last), "stalled result item changed")

  // Only successful commands carry data.
  `PLE_ASSERT_NOW(a_err_no_data, out_valid && (status != ST_OK), data_value == '0, "non-ok result item carries data")

  // Every non-ok result item closes its command's run.
  `PLE_ASSERT_NOW(a_err_last, out_valid && (status != ST_OK), last, "non-ok result item is not last")

  // A dropped insert only happens on a full list.
  `PLE_ASSERT_NOW(a_full_len, out_valid && (status == ST_FULL), list_length == FULL_LEN, "full status with list not full")

endmodule

bind positional_list_engine_unit ple_checker #(.DEPTH(DEPTH)) u_ple_checker (.*);
